@@ rtl/gdl90_tx_framer_unit_assert.svh @@
// Assertion macros for the framer RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef GDL90_TX_FRAMER_UNIT_ASSERT_SVH
`define GDL90_TX_FRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GTF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gdl90 framer: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gdl90 framer: assertion failed");

`endif

@@ rtl/gtf_pkg.sv @@
// Package for the GDL90 transmit framer: payload structs, config codes,
// queue command type and CRC-16 CCITT helpers. No dependencies.
package gtf_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FLAG   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASK   = 2'd2;

    localparam logic [7:0]  FLAG_RESET   = 8'h7E;
    localparam logic [7:0]  ESCAPE_RESET = 8'h7D;
    localparam logic [7:0]  MASK_RESET   = 8'h20;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [15:0] CRC_TOP      = 16'h8000;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } t_out_item;

    typedef struct packed {
        logic [7:0] flag_value;
        logic [7:0] escape_value;
        logic [7:0] escape_mask;
    } t_cfg;

    // One classified message byte, queued between front and back.
    typedef struct packed {
        logic        open;       // opening flag goes first
        logic [7:0]  data;
        logic        data_esc;
        logic        last;       // CRC trailer and closing flag follow
        logic [15:0] crc;
        logic        lo_esc;
        logic        hi_esc;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OPEN,
        S_ESC,
        S_DATA,
        S_LO_ESC,
        S_LO,
        S_HI_ESC,
        S_HI,
        S_CLOSE
    } t_back_state;

    function automatic logic [15:0] crc_table_entry(input logic [7:0] idx);
        logic [15:0] c;
        c = {idx, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = ((c & CRC_TOP) != 16'h0000) ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                               input logic [7:0]  b);
        return crc_table_entry(crc[15:8]) ^ {crc[7:0], 8'h00} ^ {8'h00, b};
    endfunction

    function automatic logic needs_escape(input logic [7:0] b, input t_cfg cfg);
        return (b == cfg.flag_value) || (b == cfg.escape_value);
    endfunction

endpackage

@@ rtl/gdl90_tx_framer_unit.sv @@
// GDL90 transmit framer: opening flag, byte stuffing, CRC-16 trailer, closing flag.
// Each input byte is queued, popped into the back end's command and state registers,
// then registered. Throughput: one input byte per cycle until the queue fills;
// output one byte per cycle while not stalled and not idle, 1 to 8 per input.
// Reset (synchronous, active low): no frame open, CRC zero, queue empty,
// registers at flag 0x7E, escape 0x7D, mask 0x20.
module gdl90_tx_framer_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  gtf_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output gtf_pkg::t_out_item         o_out_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [gtf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                 i_cfg_data
);
    import gtf_pkg::*;

    t_cfg r_cfg;
    t_cmd push_cmd, head_cmd;
    logic push, pop, full, empty;

    assign o_cfg_ready = 1'b1;

    // unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_value   <= FLAG_RESET;
            r_cfg.escape_value <= ESCAPE_RESET;
            r_cfg.escape_mask  <= MASK_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FLAG:   r_cfg.flag_value   <= i_cfg_data;
                REG_ESCAPE: r_cfg.escape_value <= i_cfg_data;
                REG_MASK:   r_cfg.escape_mask  <= i_cfg_data;
                default:    r_cfg <= r_cfg;
            endcase
        end
    end

    gtf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_cfg      (r_cfg),
        .i_full     (full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    gtf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head_cmd)
    );

    gtf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_empty     (empty),
        .i_head      (head_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

@@ rtl/gtf_queue.sv @@
// Short command queue between the framer front and back ends.
// Depends on gtf_pkg (t_cmd) and the assertion macros.
`include "gdl90_tx_framer_unit_assert.svh"

module gtf_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gtf_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output gtf_pkg::t_cmd o_head
);
    import gtf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    `GTF_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_push, r_count != FULL_CNT)
    `GTF_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0)
    `GTF_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == CW'($past(r_count) + 1'b1))

endmodule

@@ rtl/gtf_front.sv @@
// Front end: accepts message bytes, updates the running CRC and classifies
// each byte into a queue command. Depends on gtf_pkg.
module gtf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  gtf_pkg::t_in_item i_in_data,
    input  gtf_pkg::t_cfg     i_cfg,
    input  logic              i_full,
    output logic              o_push,
    output gtf_pkg::t_cmd     o_cmd
);
    import gtf_pkg::*;

    logic        r_in_frame, n_in_frame;
    logic [15:0] r_crc, n_crc;
    logic [15:0] crc_upd;

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

    // crc is held at zero between frames, so no reload on open
    assign crc_upd = crc_update(r_crc, i_in_data.msg_byte);

    always_comb begin
        o_cmd.open     = !r_in_frame;
        o_cmd.data     = i_in_data.msg_byte;
        o_cmd.data_esc = needs_escape(i_in_data.msg_byte, i_cfg);
        o_cmd.last     = i_in_data.end_of_message;
        o_cmd.crc      = crc_upd;
        o_cmd.lo_esc   = needs_escape(crc_upd[7:0], i_cfg);
        o_cmd.hi_esc   = needs_escape(crc_upd[15:8], i_cfg);
    end

    always_comb begin
        n_in_frame = r_in_frame;
        n_crc      = r_crc;
        if (o_push) begin
            if (i_in_data.end_of_message) begin
                n_in_frame = 1'b0;
                n_crc      = '0;
            end else begin
                n_in_frame = 1'b1;
                n_crc      = crc_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_crc      <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_crc      <= n_crc;
        end
    end

endmodule

@@ rtl/gtf_back.sv @@
// Back end: walks each queued command through flag, stuffed byte, CRC
// trailer and closing flag, one byte per unstalled cycle. Uses gtf_pkg.
module gtf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gtf_pkg::t_cfg      i_cfg,
    input  logic               i_empty,
    input  gtf_pkg::t_cmd      i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output gtf_pkg::t_out_item o_out_data
);
    import gtf_pkg::*;

    t_back_state r_state, n_state, seq_next;
    t_cmd        r_cmd;
    t_out_item   r_out, emit_item;
    logic        r_out_valid;
    logic        emit;

    function automatic t_back_state first_state(input t_cmd c);
        if (c.open) begin
            return S_OPEN;
        end
        return c.data_esc ? S_ESC : S_DATA;
    endfunction

    // output slot is free or drains this cycle
    assign emit = (r_state != S_IDLE) && (!r_out_valid || i_out_ready);

    // next state
    always_comb begin
        case (r_state)
            S_OPEN:   seq_next = r_cmd.data_esc ? S_ESC : S_DATA;
            S_ESC:    seq_next = S_DATA;
            S_DATA: begin
                if (r_cmd.last) begin
                    seq_next = r_cmd.lo_esc ? S_LO_ESC : S_LO;
                end else begin
                    seq_next = S_IDLE;
                end
            end
            S_LO_ESC: seq_next = S_LO;
            S_LO:     seq_next = r_cmd.hi_esc ? S_HI_ESC : S_HI;
            S_HI_ESC: seq_next = S_HI;
            S_HI:     seq_next = S_CLOSE;
            S_CLOSE:  seq_next = S_IDLE;
            default:  seq_next = S_IDLE;
        endcase

        o_pop   = 1'b0;
        n_state = r_state;
        if (r_state == S_IDLE) begin
            if (!i_empty) begin
                o_pop   = 1'b1;
                n_state = first_state(i_head);
            end
        end else if (emit) begin
            if (seq_next != S_IDLE) begin
                n_state = seq_next;
            end else if (!i_empty) begin
                o_pop   = 1'b1;
                n_state = first_state(i_head);
            end else begin
                n_state = S_IDLE;
            end
        end
    end

    // outputs
    always_comb begin
        emit_item.frame_end = 1'b0;
        case (r_state)
            S_OPEN:   emit_item.out_byte = i_cfg.flag_value;
            S_ESC:    emit_item.out_byte = i_cfg.escape_value;
            S_DATA:   emit_item.out_byte = r_cmd.data
                                         ^ (r_cmd.data_esc ? i_cfg.escape_mask : 8'h00);
            S_LO_ESC: emit_item.out_byte = i_cfg.escape_value;
            S_LO:     emit_item.out_byte = r_cmd.crc[7:0]
                                         ^ (r_cmd.lo_esc ? i_cfg.escape_mask : 8'h00);
            S_HI_ESC: emit_item.out_byte = i_cfg.escape_value;
            S_HI:     emit_item.out_byte = r_cmd.crc[15:8]
                                         ^ (r_cmd.hi_esc ? i_cfg.escape_mask : 8'h00);
            S_CLOSE: begin
                emit_item.out_byte  = i_cfg.flag_value;
                emit_item.frame_end = 1'b1;
            end
            default:  emit_item.out_byte = i_cfg.flag_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head;
        end
        if (emit) begin
            r_out <= emit_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
